>>> src/kpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Types, codes and constants shared by the key long-press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int MAX_KEYS = 12;
    localparam int KEY_W    = 4;
    localparam int PIN_W    = 5;
    localparam int TS_W     = 32;
    localparam int CFG_W    = 20;
    localparam int THR_W    = 31;
    localparam int GAP_W    = 2;
    localparam int ACT_W    = 2;
    localparam int CIDX_W   = 2;

    // opcodes
    localparam logic OP_PIN_EDGE = 1'b0;
    localparam logic OP_PROCESS  = 1'b1;

    // pin level after an edge
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // link state
    localparam logic [GAP_W-1:0] GAP_IDLE      = 2'd0;
    localparam logic [GAP_W-1:0] GAP_ADVERTISE = 2'd1;
    localparam logic [GAP_W-1:0] GAP_CONNECTED = 2'd2;

    // link actions
    localparam logic [ACT_W-1:0] ACT_NONE       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADV_ON     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADV_OFF    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DISCONNECT = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_POWER_PRESS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESET_PRESS = 2'd2;

    // key numbers
    localparam logic [KEY_W-1:0] KEY_NONE = 4'd0;
    localparam logic [KEY_W-1:0] KEY_ONE  = 4'd1;
    localparam logic [KEY_W-1:0] KEY_TWO  = 4'd2;

    localparam int US_PER_MS       = 1000;
    localparam int TICK_PERIOD_RST = 10;
    localparam int POWER_PRESS_RST = 3000;
    localparam int RESET_PRESS_RST = 6000;

    // thresholds in microseconds, so the ms division folds into the compare:
    // ms > P  <=>  us >= (P+1)*1000,  ms < R  <=>  us < R*1000
    localparam logic [THR_W-1:0] THR_POWER_MIN_RST = THR_W'((POWER_PRESS_RST + 1) * US_PER_MS);
    localparam logic [THR_W-1:0] THR_POWER_MAX_RST = THR_W'(RESET_PRESS_RST * US_PER_MS);
    localparam logic [THR_W-1:0] THR_RESET_MIN_RST = THR_W'((RESET_PRESS_RST + 1) * US_PER_MS);

    typedef logic [MAX_KEYS-1:0] t_mask;

    typedef struct packed {
        logic               opcode;
        logic [PIN_W-1:0]   pin;
        logic               pin_level;
        logic [TS_W-1:0]    timestamp;
        logic [GAP_W-1:0]   gap_state;
        logic               adv_on;
    } t_in_item;

    typedef struct packed {
        t_mask              key_mask;
        logic               changed;
        logic               update_advertising;
        logic [ACT_W-1:0]   adv_action;
        logic               factory_reset;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]   tick_period_us;
        logic [THR_W-1:0]   thr_power_min;
        logic [THR_W-1:0]   thr_power_max;
        logic [THR_W-1:0]   thr_reset_min;
    } t_cfg;

    // process event on its way to the decision stage
    typedef struct packed {
        t_mask              key_mask;
        logic               changed;
        logic [GAP_W-1:0]   gap_state;
        logic               adv_on;
        logic               key1_released;
        logic               pair_broken;
        logic               from_key1;
        logic [TS_W-1:0]    us_key1;
        logic [TS_W-1:0]    us_key2;
    } t_mid;

    function automatic logic [KEY_W-1:0] key_of_pin(input logic [PIN_W-1:0] pin);
        logic [KEY_W-1:0] key;
        case (pin)
            5'd4:    key = 4'd1;
            5'd0:    key = 4'd2;
            5'd12:   key = 4'd3;
            5'd1:    key = 4'd4;
            5'd2:    key = 4'd5;
            5'd3:    key = 4'd6;
            5'd5:    key = 4'd7;
            5'd6:    key = 4'd8;
            5'd7:    key = 4'd9;
            5'd8:    key = 4'd10;
            5'd9:    key = 4'd11;
            5'd11:   key = 4'd12;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

>>> src/kpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_cfg
// Configuration registers; press limits are held pre-scaled to microseconds.
// ----------------------------------------------------------------------------
module kpc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [kpc_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [kpc_pkg::CFG_W-1:0]         i_cfg_data,
    output kpc_pkg::t_cfg                     o_cfg
);

    kpc_pkg::t_cfg r_cfg;
    kpc_pkg::t_cfg n_cfg;

    logic [kpc_pkg::THR_W-1:0] data_us;
    logic [kpc_pkg::THR_W-1:0] data_p1_us;

    // constant multiplies by 1000
    assign data_us    = kpc_pkg::THR_W'(i_cfg_data) * kpc_pkg::THR_W'(kpc_pkg::US_PER_MS);
    assign data_p1_us = data_us + kpc_pkg::THR_W'(kpc_pkg::US_PER_MS);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kpc_pkg::CFG_TICK_PERIOD: n_cfg.tick_period_us = i_cfg_data;
                kpc_pkg::CFG_POWER_PRESS: n_cfg.thr_power_min  = data_p1_us;
                kpc_pkg::CFG_RESET_PRESS: begin
                    n_cfg.thr_power_max = data_us;
                    n_cfg.thr_reset_min = data_p1_us;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period_us <= kpc_pkg::CFG_W'(kpc_pkg::TICK_PERIOD_RST);
            r_cfg.thr_power_min  <= kpc_pkg::THR_POWER_MIN_RST;
            r_cfg.thr_power_max  <= kpc_pkg::THR_POWER_MAX_RST;
            r_cfg.thr_reset_min  <= kpc_pkg::THR_RESET_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/kpc_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_track
// Input register, key mask and key 1/2 timestamps, press length products.
// ----------------------------------------------------------------------------
module kpc_track #(
    parameter int NUM_KEYS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  kpc_pkg::t_in_item    i_item,
    input  kpc_pkg::t_cfg        i_cfg,
    output logic                 o_mid_valid,
    input  logic                 i_mid_ready,
    output kpc_pkg::t_mid        o_mid
);

    localparam int MASK_W = (NUM_KEYS < kpc_pkg::MAX_KEYS) ? NUM_KEYS : kpc_pkg::MAX_KEYS;
    localparam logic [kpc_pkg::KEY_W:0] KEY_LIM = (kpc_pkg::KEY_W + 1)'(NUM_KEYS);

    logic                       r_s1_valid;
    kpc_pkg::t_in_item          r_s1_item;
    logic [MASK_W-1:0]          r_mask;
    logic [MASK_W-1:0]          n_mask;
    logic [MASK_W-1:0]          r_prev;
    logic [kpc_pkg::TS_W-1:0]   r_press   [2];
    logic [kpc_pkg::TS_W-1:0]   r_release [2];

    logic                       s1_is_proc;
    logic                       s1_go;
    logic                       s1_fire;
    logic                       accept;
    logic                       edge_fire;
    logic                       proc_fire;
    logic [kpc_pkg::KEY_W-1:0]  key;
    logic [kpc_pkg::KEY_W-1:0]  key_idx;
    logic                       key_ok;
    logic                       key_timed;
    kpc_pkg::t_mask             key_bit;
    kpc_pkg::t_mask             mask_now;
    kpc_pkg::t_mask             mask_prev;
    kpc_pkg::t_mask             mask_upd;
    logic [kpc_pkg::TS_W-1:0]   diff1;
    logic [kpc_pkg::TS_W-1:0]   diff2;
    logic [kpc_pkg::TS_W-1:0]   tick;

    assign s1_is_proc = (r_s1_item.opcode == kpc_pkg::OP_PROCESS);
    assign s1_go      = !s1_is_proc || i_mid_ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign o_stall    = !i_rst_n || (r_s1_valid && !s1_go);
    assign accept     = i_valid && !o_stall;
    assign edge_fire  = s1_fire && !s1_is_proc && key_ok;
    assign proc_fire  = s1_fire && s1_is_proc;

    assign key       = kpc_pkg::key_of_pin(r_s1_item.pin);
    assign key_idx   = key - kpc_pkg::KEY_ONE;
    assign key_ok    = (key != kpc_pkg::KEY_NONE) && ({1'b0, key} <= KEY_LIM);
    assign key_timed = (key == kpc_pkg::KEY_ONE) || (key == kpc_pkg::KEY_TWO);
    assign key_bit   = kpc_pkg::t_mask'(1) << key_idx;

    always_comb begin
        mask_now  = '0;
        mask_prev = '0;
        mask_now[MASK_W-1:0]  = r_mask;
        mask_prev[MASK_W-1:0] = r_prev;
    end

    assign mask_upd = (r_s1_item.pin_level == kpc_pkg::LVL_RELEASED) ?
                      (mask_now & ~key_bit) : (mask_now | key_bit);
    assign n_mask   = mask_upd[MASK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_mask       <= '0;
            r_prev       <= '0;
            r_press[0]   <= '0;
            r_press[1]   <= '0;
            r_release[0] <= '0;
            r_release[1] <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (edge_fire) begin
                r_mask <= n_mask;
                if (key_timed) begin
                    if (r_s1_item.pin_level == kpc_pkg::LVL_RELEASED) begin
                        r_release[key_idx[0]] <= r_s1_item.timestamp;
                    end else begin
                        r_press[key_idx[0]] <= r_s1_item.timestamp;
                    end
                end
            end
            if (proc_fire) begin
                r_prev <= r_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
        end
    end

    // tick difference times period, wrapping at 32 bits
    assign tick  = kpc_pkg::TS_W'(i_cfg.tick_period_us);
    assign diff1 = r_release[0] - r_press[0];
    assign diff2 = r_release[1] - r_press[1];

    assign o_mid_valid = r_s1_valid && s1_is_proc;

    always_comb begin
        o_mid.key_mask      = mask_now;
        o_mid.changed       = (mask_now != mask_prev);
        o_mid.gap_state     = r_s1_item.gap_state;
        o_mid.adv_on        = r_s1_item.adv_on;
        o_mid.key1_released = mask_prev[0] && !mask_now[0];
        o_mid.pair_broken   = (mask_prev[1:0] == 2'b11) && (mask_now[1:0] != 2'b11);
        o_mid.from_key1     = mask_prev[0] ^ mask_now[0];
        o_mid.us_key1       = diff1 * tick;
        o_mid.us_key2       = diff2 * tick;
    end

endmodule

>>> src/kpc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_judge
// Length register, threshold compares and the result register.
// ----------------------------------------------------------------------------
module kpc_judge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mid_valid,
    output logic                 o_mid_ready,
    input  kpc_pkg::t_mid        i_mid,
    input  kpc_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output kpc_pkg::t_out_item   o_item
);

    logic                   r_s2_valid;
    kpc_pkg::t_mid          r_s2;
    logic                   r_out_valid;
    kpc_pkg::t_out_item     r_out;
    kpc_pkg::t_out_item     n_out;

    logic                       s2_go;
    logic                       s2_load;
    logic [kpc_pkg::TS_W-1:0]   us_pair;
    logic                       power_hit;
    logic                       reset_hit;

    assign s2_go       = !r_out_valid || !i_stall;
    assign o_mid_ready = !r_s2_valid || s2_go;
    assign s2_load     = i_mid_valid && o_mid_ready;

    // key 1 decides when its bit changed, otherwise key 2
    assign us_pair   = r_s2.from_key1 ? r_s2.us_key1 : r_s2.us_key2;
    assign power_hit = (r_s2.us_key1 >= kpc_pkg::TS_W'(i_cfg.thr_power_min)) &&
                       (r_s2.us_key1 <  kpc_pkg::TS_W'(i_cfg.thr_power_max));
    assign reset_hit = us_pair >= kpc_pkg::TS_W'(i_cfg.thr_reset_min);

    always_comb begin
        n_out.key_mask           = r_s2.key_mask;
        n_out.changed            = r_s2.changed;
        n_out.update_advertising = r_s2.changed &&
                                   (r_s2.gap_state == kpc_pkg::GAP_ADVERTISE);
        n_out.adv_action         = kpc_pkg::ACT_NONE;
        if (r_s2.changed && r_s2.key1_released) begin
            if (r_s2.gap_state == kpc_pkg::GAP_CONNECTED) begin
                if (power_hit) begin
                    n_out.adv_action = kpc_pkg::ACT_DISCONNECT;
                end
            end else if (r_s2.adv_on) begin
                n_out.adv_action = kpc_pkg::ACT_ADV_OFF;
            end else begin
                n_out.adv_action = kpc_pkg::ACT_ADV_ON;
            end
        end
        n_out.factory_reset = r_s2.changed && r_s2.pair_broken && reset_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_go) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2 <= i_mid;
        end
        if (s2_go && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

>>> src/key_long_press_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_long_press_classifier_unit
// Tracks pressed keys from pin edges and classifies presses on process events.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | in        | i_valid / o_stall      | i_item  (kpc_pkg::t_in_item)
//  out      | out       | o_valid / i_stall      | o_item  (kpc_pkg::t_out_item)
//  cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item per cycle while o_stall is low. A pin edge updates the key state
//  as it leaves the input register and gives no result. A process event
//  passes the input register, the length register (fed by the two 32-bit
//  press-length multipliers) and the result register, in that order.
//  Synchronous reset clears keys, timestamps and valid flags; no clearing pass.
//  i_stall holds the result register and backs up through o_stall.
// ----------------------------------------------------------------------------
module key_long_press_classifier_unit #(
    parameter int NUM_KEYS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  kpc_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output kpc_pkg::t_out_item            o_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kpc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [kpc_pkg::CFG_W-1:0]     i_cfg_data
);

    kpc_pkg::t_cfg  cfg;
    kpc_pkg::t_mid  mid;
    logic           mid_valid;
    logic           mid_ready;

    assign o_cfg_ready = i_rst_n;

    kpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kpc_track #(
        .NUM_KEYS (NUM_KEYS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid       (mid)
    );

    kpc_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid       (mid),
        .i_cfg       (cfg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

>>> src/kpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
module kpc_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  kpc_pkg::t_out_item    i_out_item
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an unchanged mask must never trigger any action
    a_quiet_when_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.changed |->
            !i_out_item.update_advertising && !i_out_item.factory_reset &&
            (i_out_item.adv_action == kpc_pkg::ACT_NONE))
        else $error("action reported without a mask change");

    // a release of key 1 or 2 means bit 0 or 1 is clear in the reported mask
    a_reset_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.factory_reset |->
            (i_out_item.key_mask[1:0] != 2'b11))
        else $error("factory reset while both keys still held");

endmodule

bind key_long_press_classifier_unit kpc_checker u_kpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_item  (o_item)
);
